// ===== sv/ucbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucbb_pkg
// Shared types, constants and the kernel coefficient table of the cubic
// B-spline basis row generator.
// ----------------------------------------------------------------------------
package ucbb_pkg;

   // fixed field widths
   localparam int TS_W      = 32;
   localparam int SCALE_W   = 32;
   localparam int KC_W      = 5;
   localparam int IDX_W     = 5;
   localparam int VAL_W     = 17;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 24;
   localparam int IDX_LSB   = 0;
   localparam int VAL_LSB   = IDX_W;

   // fixed point
   localparam int FRAC_W    = 24;
   localparam int T_W       = FRAC_W + 1;
   localparam int COEF_W    = 8;
   localparam int N_W       = 34;
   localparam int DIV_SHIFT = 10;
   localparam int A_W       = 22;
   localparam int RECIP_W   = 23;
   localparam int RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP3     = 23'd2796203;
   localparam logic signed [N_W-1:0] ROUND_BIAS = 34'sd1536;
   localparam logic [VAL_W-1:0] VAL_MAX      = 17'd65536;

   // configuration
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KNOT_COUNT  = 2'd2;
   localparam logic [TS_W-1:0]    TIME_OFFSET_RST = 32'd0;
   localparam logic [SCALE_W-1:0] TIME_SCALE_RST  = 32'd16777216;
   localparam logic [KC_W-1:0]    KNOT_COUNT_RST  = 5'd16;
   localparam int KC_MIN = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_END1 = 2'd0,
      KIND_END2 = 2'd1,
      KIND_END3 = 2'd2,
      KIND_MID  = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] c0;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c3;
   } coef_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic              valid;
      logic [QLVL_W-1:0] level;
   } queue_status_type;

   // polynomial coefficients (times 12) of one kernel segment in local t
   function automatic coef_type coef_lookup(input kind_type kind, input logic [1:0] seg);
      coef_type c;
      c = '{c0: 8'sd0, c1: 8'sd0, c2: 8'sd0, c3: 8'sd0};
      case (kind)
         KIND_END1: begin
            if (seg == 2'd0) c = '{c0: 8'sd12, c1: -8'sd36, c2: 8'sd36, c3: -8'sd12};
         end
         KIND_END2: begin
            case (seg)
               2'd0:    c = '{c0: 8'sd0, c1: 8'sd36, c2: -8'sd54, c3: 8'sd21};
               2'd1:    c = '{c0: 8'sd3, c1: -8'sd9, c2: 8'sd9,   c3: -8'sd3};
               default: c = '{c0: 8'sd0, c1: 8'sd0,  c2: 8'sd0,   c3: 8'sd0};
            endcase
         end
         KIND_END3: begin
            case (seg)
               2'd0:    c = '{c0: 8'sd0, c1: 8'sd0,  c2: 8'sd18,  c3: -8'sd11};
               2'd1:    c = '{c0: 8'sd7, c1: 8'sd3,  c2: -8'sd15, c3: 8'sd7};
               2'd2:    c = '{c0: 8'sd2, c1: -8'sd6, c2: 8'sd6,   c3: -8'sd2};
               default: c = '{c0: 8'sd0, c1: 8'sd0,  c2: 8'sd0,   c3: 8'sd0};
            endcase
         end
         KIND_MID: begin
            case (seg)
               2'd0:    c = '{c0: 8'sd0, c1: 8'sd0,  c2: 8'sd0,   c3: 8'sd2};
               2'd1:    c = '{c0: 8'sd2, c1: 8'sd6,  c2: 8'sd6,   c3: -8'sd6};
               2'd2:    c = '{c0: 8'sd8, c1: 8'sd0,  c2: -8'sd12, c3: 8'sd6};
               default: c = '{c0: 8'sd2, c1: -8'sd6, c2: 8'sd6,   c3: -8'sd2};
            endcase
         end
         default: c = '{c0: 8'sd0, c1: 8'sd0, c2: 8'sd0, c3: 8'sd0};
      endcase
      return c;
   endfunction

endpackage

// ===== sv/ucbb_queue.sv =====
// ----------------------------------------------------------------------------
// ucbb_queue
// Small register queue carrying mapped knot coordinates from front to back.
// ----------------------------------------------------------------------------
module ucbb_queue import ucbb_pkg::*; #(
   parameter int WIDTH = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic signed [WIDTH-1:0] push_data,
   input  logic                    pop,
   output queue_status_type        status,
   output logic signed [WIDTH-1:0] head_data
);

   logic signed [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]       level_ff, level_in;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) level_in = QLVL_W'(level_ff + 1'b1);
      if (!push && pop) level_in = QLVL_W'(level_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.valid = (level_ff != '0);
   assign status.level = level_ff;

endmodule

// ===== sv/ucbb_front.sv =====
// ----------------------------------------------------------------------------
// ucbb_front
// Accepts time samples and maps each to the clamped knot coordinate
// u = (time - offset) * scale in Q.24 over a three-stage pipeline.
// ----------------------------------------------------------------------------
module ucbb_front import ucbb_pkg::*; #(
   parameter int MAX_KNOTS = 16,
   parameter int U_W       = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_W-1:0]        req_tdata,    // [31:0] time_sample
   input  logic [TS_W-1:0]         time_offset,
   input  logic [SCALE_W-1:0]      time_scale,
   input  queue_status_type        q_status,
   output logic                    push_vld,
   output logic signed [U_W-1:0]   push_u
);

   localparam int MAG_W    = TS_W + 1;
   localparam int MAG_LO_W = 16;
   localparam int MAG_HI_W = MAG_W - MAG_LO_W;
   localparam int PL_W     = MAG_LO_W + SCALE_W;
   localparam int PH_W     = MAG_HI_W + SCALE_W;
   localparam int PROD_W   = PH_W + 1;
   localparam int USED_W   = QLVL_W + 1;
   localparam logic [PROD_W-1:0] U_HI  = PROD_W'(MAX_KNOTS + 1) << FRAC_W;
   localparam logic [PROD_W-1:0] U_ONE = PROD_W'(1) << FRAC_W;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [MAG_W-1:0] d_ff, d_in;
   logic                    neg2_ff, neg3_ff;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [PL_W-1:0]         pl_ff, pl_in;
   logic [PH_W-1:0]         ph_ff, ph_in;
   logic [USED_W-1:0]       used;
   logic                    accept;
   logic [PROD_W-1:0]       prod, lim, prod_c;

   // room in the queue for every item still in flight
   always_comb begin
      used = USED_W'(q_status.level) + USED_W'(v1_ff) + USED_W'(v2_ff) + USED_W'(v3_ff);
      req_tready = (used < USED_W'(QUEUE_DEPTH));
   end
   assign accept = req_tvalid && req_tready;

   // difference, magnitude and split partial products
   always_comb begin
      d_in   = $signed({req_tdata[TS_W-1], req_tdata}) - $signed({time_offset[TS_W-1], time_offset});
      mag_in = d_ff[MAG_W-1] ? MAG_W'(-d_ff) : MAG_W'(d_ff);
      pl_in  = PL_W'(mag_ff[MAG_LO_W-1:0]) * PL_W'(time_scale);
      ph_in  = PH_W'(mag_ff[MAG_W-1:MAG_LO_W]) * PH_W'(time_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      neg2_ff <= d_ff[MAG_W-1];
      mag_ff  <= mag_in;
      neg3_ff <= neg2_ff;
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
   end

   // recombine, drop 16 fraction bits, clamp and restore the sign
   always_comb begin
      prod   = PROD_W'(ph_ff) + PROD_W'(pl_ff >> MAG_LO_W);
      lim    = neg3_ff ? U_ONE : U_HI;
      prod_c = (prod > lim) ? lim : prod;
      push_u = neg3_ff ? -$signed(U_W'(prod_c)) : $signed(U_W'(prod_c));
   end
   assign push_vld = v3_ff;

endmodule

// ===== sv/ucbb_back.sv =====
// ----------------------------------------------------------------------------
// ucbb_back
// Column sequencer and kernel evaluation pipeline: takes one coordinate from
// the queue and streams its knot_count+3 basis values, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ucbb_back import ucbb_pkg::*; #(
   parameter int MAX_KNOTS = 16,
   parameter int U_W       = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_KNOTS+1)-1:0]  nk,
   input  queue_status_type                q_status,
   input  logic signed [U_W-1:0]           q_u,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_W-1:0]                rsp_tdata,   // [4:0] basis_index, [21:5] basis_value
   output logic                            rsp_tlast
);

   localparam int COL_W = $clog2(MAX_KNOTS + 3);
   localparam int PAD_W = RSP_W - IDX_W - VAL_W;

   // sequencer
   logic                  busy_ff, busy_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic signed [U_W-1:0] u_ff, mir_ff;
   logic                  adv, issue, issue_last, load, is_last;
   logic [COL_W-1:0]      cnt_m1, km3;
   kind_type              sel_kind;
   logic signed [U_W-1:0] sel_x;

   // pipeline stages
   logic                  a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff;
   logic                  o_vld_ff;
   logic signed [U_W-1:0] a_x_ff;
   kind_type              a_kind_ff;
   meta_type              a_meta_ff, b_meta_ff, c_meta_ff, d_meta_ff, e_meta_ff;
   meta_type              f_meta_ff, o_meta_ff;
   logic [T_W-1:0]        b_t_ff, b_t_in, c_t_ff, d_t_ff;
   logic [T_W-1:0]        c_t2_ff, c_t2_in, d_t2_ff, d_t3_ff, d_t3_in;
   logic                  b_zero_ff, b_zero_in, c_zero_ff, d_zero_ff, e_zero_ff;
   coef_type              b_coef_ff, b_coef_in, c_coef_ff, d_coef_ff;
   logic signed [COEF_W-1:0] e_c0_ff;
   logic signed [N_W-1:0] e_p1_ff, e_p2_ff, e_p3_ff, e_p1_in, e_p2_in, e_p3_in;
   logic [A_W-1:0]        f_a_ff, f_a_in;
   logic                  f_kill_ff, f_kill_in;
   logic [VAL_W-1:0]      o_val_ff, o_val_in;

   // stage b helpers
   logic signed [U_W-1:0] x_m1, len_q;
   logic [2:0]            klen;
   logic                  x_zero;
   logic [1:0]            seg;
   // stage c, d, f, out helpers
   logic [2*T_W-1:0]      tt_prod, t3_prod;
   logic signed [N_W-1:0] c0_term, n_sum, n_bias;
   logic [A_W+RECIP_W-1:0] q_prod;
   logic [A_W-1:0]        q_val;

   assign adv        = !o_vld_ff || rsp_tready;
   assign cnt_m1     = COL_W'(nk) + COL_W'(2);
   assign is_last    = (col_ff == cnt_m1);
   assign issue      = busy_ff && adv;
   assign issue_last = issue && is_last;
   assign load       = q_status.valid && (!busy_ff || issue_last);
   assign q_pop      = load;

   // column sequencing
   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      if (issue) col_in = COL_W'(col_ff + 1'b1);
      if (issue_last) busy_in = 1'b0;
      if (load) begin
         busy_in = 1'b1;
         col_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         col_ff  <= col_in;
      end
   end

   // coordinate and its mirror about the right end
   always_ff @(posedge clock) begin
      if (load) begin
         u_ff   <= q_u;
         mir_ff <= $signed(U_W'({nk, FRAC_W'(0)})) - q_u;
      end
   end

   // kernel kind and argument of the current column
   always_comb begin
      km3 = COL_W'(col_ff - COL_W'(3));
      if (col_ff < COL_W'(3)) begin
         sel_kind = kind_type'(col_ff[1:0]);
         sel_x    = u_ff;
      end else if (col_ff >= COL_W'(nk)) begin
         sel_kind = kind_type'(2'(cnt_m1 - col_ff));
         sel_x    = mir_ff;
      end else begin
         sel_kind = KIND_MID;
         sel_x    = u_ff - $signed(U_W'({km3, FRAC_W'(0)}));
      end
   end

   // support test, segment and local t
   always_comb begin
      x_zero    = (a_x_ff == '0);
      x_m1      = a_x_ff - $signed(U_W'(1));
      klen      = {1'b0, a_kind_ff} + 3'd1;
      len_q     = $signed(U_W'({klen, FRAC_W'(0)}));
      b_zero_in = a_x_ff[U_W-1] || (a_x_ff > len_q) || (x_zero && a_kind_ff != KIND_END1);
      seg       = x_zero ? 2'd0 : x_m1[FRAC_W+1:FRAC_W];
      b_t_in    = x_zero ? '0 : T_W'(x_m1[FRAC_W-1:0]) + T_W'(1);
      b_coef_in = coef_lookup(a_kind_ff, seg);
   end

   // powers of t
   always_comb begin
      tt_prod = (2*T_W)'(b_t_ff) * (2*T_W)'(b_t_ff);
      c_t2_in = tt_prod[FRAC_W+T_W-1:FRAC_W];
      t3_prod = (2*T_W)'(c_t2_ff) * (2*T_W)'(c_t_ff);
      d_t3_in = t3_prod[FRAC_W+T_W-1:FRAC_W];
   end

   // coefficient products
   always_comb begin
      e_p1_in = $signed(d_coef_ff.c1) * $signed(N_W'(d_t_ff));
      e_p2_in = $signed(d_coef_ff.c2) * $signed(N_W'(d_t2_ff));
      e_p3_in = $signed(d_coef_ff.c3) * $signed(N_W'(d_t3_ff));
   end

   // polynomial sum, rounding bias and division by 1024
   always_comb begin
      c0_term   = {{(N_W-COEF_W-FRAC_W){e_c0_ff[COEF_W-1]}}, e_c0_ff, FRAC_W'(0)};
      n_sum     = c0_term + e_p1_ff + e_p2_ff + e_p3_ff;
      n_bias    = n_sum + ROUND_BIAS;
      f_kill_in = e_zero_ff || n_sum[N_W-1];
      f_a_in    = n_bias[DIV_SHIFT+A_W-1:DIV_SHIFT];
   end

   // division by three through the reciprocal, then saturation
   always_comb begin
      q_prod = (A_W+RECIP_W)'(f_a_ff) * (A_W+RECIP_W)'(RECIP3);
      q_val  = A_W'(q_prod >> RECIP_SHIFT);
      if (f_kill_ff)                   o_val_in = '0;
      else if (q_val > A_W'(VAL_MAX))  o_val_in = VAL_MAX;
      else                             o_val_in = VAL_W'(q_val);
   end

   // valid chain, all stages move together with the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         o_vld_ff <= f_vld_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff         <= sel_x;
         a_kind_ff      <= sel_kind;
         a_meta_ff.idx  <= IDX_W'(col_ff);
         a_meta_ff.last <= is_last;
         b_t_ff         <= b_t_in;
         b_zero_ff      <= b_zero_in;
         b_coef_ff      <= b_coef_in;
         b_meta_ff      <= a_meta_ff;
         c_t_ff         <= b_t_ff;
         c_t2_ff        <= c_t2_in;
         c_zero_ff      <= b_zero_ff;
         c_coef_ff      <= b_coef_ff;
         c_meta_ff      <= b_meta_ff;
         d_t_ff         <= c_t_ff;
         d_t2_ff        <= c_t2_ff;
         d_t3_ff        <= d_t3_in;
         d_zero_ff      <= c_zero_ff;
         d_coef_ff      <= c_coef_ff;
         d_meta_ff      <= c_meta_ff;
         e_p1_ff        <= e_p1_in;
         e_p2_ff        <= e_p2_in;
         e_p3_ff        <= e_p3_in;
         e_c0_ff        <= d_coef_ff.c0;
         e_zero_ff      <= d_zero_ff;
         e_meta_ff      <= d_meta_ff;
         f_a_ff         <= f_a_in;
         f_kill_ff      <= f_kill_in;
         f_meta_ff      <= e_meta_ff;
         o_val_ff       <= o_val_in;
         o_meta_ff      <= f_meta_ff;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {PAD_W'(0), o_val_ff, o_meta_ff.idx};
   assign rsp_tlast  = o_meta_ff.last;

endmodule

// ===== sv/uniform_cubic_bspline_basis_top.sv =====
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_basis_top
// Clamped uniform cubic B-spline basis row generator.
// ----------------------------------------------------------------------------
// Each time sample on the req_ stream yields knot_count+3 transfers on the
// rsp_ stream (19 at the reset count of 16), one basis column per cycle
// while rsp_tready holds, with tlast on the final column; knot counts below
// 4 or above MAX_KNOTS act as the nearest bound. The column sequencer issues
// one column per cycle while the output is not stalled, so a steady stream of
// samples comes out back to back with no gap between rows. A sample passes
// the coordinate mapping front end, the queue and the kernel pipeline stages
// a to f with the output register. Samples are taken while a 4-entry queue
// between the two halves has room. Configuration writes take effect at once
// and must be made while no row is pending.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_basis_top import ucbb_pkg::*; #(
   parameter int MAX_KNOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,    // [31:0] time_sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,    // [4:0] basis_index, [21:5] basis_value
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int NK_W = $clog2(MAX_KNOTS + 1);
   localparam int U_W  = $clog2(MAX_KNOTS + 2) + FRAC_W + 1;

   logic [TS_W-1:0]       time_offset_ff, time_offset_in;
   logic [SCALE_W-1:0]    time_scale_ff, time_scale_in;
   logic [KC_W-1:0]       knot_count_ff, knot_count_in;
   logic [NK_W-1:0]       nk;
   queue_status_type      q_status;
   logic                  push_vld, q_pop;
   logic signed [U_W-1:0] push_u, q_u;

   // configuration registers
   always_comb begin
      time_offset_in = time_offset_ff;
      time_scale_in  = time_scale_ff;
      knot_count_in  = knot_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TIME_OFFSET: time_offset_in = csr_wdata[TS_W-1:0];
            REG_TIME_SCALE:  time_scale_in  = csr_wdata[SCALE_W-1:0];
            REG_KNOT_COUNT:  knot_count_in  = csr_wdata[KC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_offset_ff <= TIME_OFFSET_RST;
         time_scale_ff  <= TIME_SCALE_RST;
         knot_count_ff  <= KNOT_COUNT_RST;
      end else begin
         time_offset_ff <= time_offset_in;
         time_scale_ff  <= time_scale_in;
         knot_count_ff  <= knot_count_in;
      end
   end

   // effective knot count
   always_comb begin
      if (int'(knot_count_ff) < KC_MIN)         nk = NK_W'(KC_MIN);
      else if (int'(knot_count_ff) > MAX_KNOTS) nk = NK_W'(MAX_KNOTS);
      else                                      nk = NK_W'(knot_count_ff);
   end

   ucbb_front #(
      .MAX_KNOTS (MAX_KNOTS),
      .U_W       (U_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .time_offset (time_offset_ff),
      .time_scale  (time_scale_ff),
      .q_status    (q_status),
      .push_vld    (push_vld),
      .push_u      (push_u)
   );

   ucbb_queue #(
      .WIDTH (U_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_vld),
      .push_data (push_u),
      .pop       (q_pop),
      .status    (q_status),
      .head_data (q_u)
   );

   ucbb_back #(
      .MAX_KNOTS (MAX_KNOTS),
      .U_W       (U_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .nk         (nk),
      .q_status   (q_status),
      .q_u        (q_u),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/ucbb_checker.sv =====
// ----------------------------------------------------------------------------
// ucbb_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ucbb_checker import ucbb_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   logic             xfer;
   logic             prev_last_ff;
   logic [IDX_W-1:0] prev_idx_ff;
   logic [IDX_W-1:0] idx;
   logic [VAL_W-1:0] val;

   assign xfer = rsp_tvalid && rsp_tready;
   assign idx  = rsp_tdata[IDX_LSB +: IDX_W];
   assign val  = rsp_tdata[VAL_LSB +: VAL_W];

   // track the previous result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
         prev_idx_ff  <= '0;
      end else if (xfer) begin
         prev_last_ff <= rsp_tlast;
         prev_idx_ff  <= idx;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_row_start: assert property (@(posedge clock) disable iff (reset)
      xfer && prev_last_ff |-> idx == '0)
      else $error("row does not start at column zero");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      xfer && !prev_last_ff |-> idx == IDX_W'(prev_idx_ff + 1'b1))
      else $error("column skipped or repeated");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> val <= VAL_MAX)
      else $error("basis value above one");

endmodule

bind uniform_cubic_bspline_basis_top ucbb_checker u_ucbb_checker (.*);
